// File: src/cri_pkg.sv
// Shared types and constants of the Catmull-Rom interpolator.
package cri_pkg;

    // Table read address source
    typedef enum logic [1:0] {
        RD_ZERO  = 2'd0,
        RD_LAST  = 2'd1,
        RD_MID   = 2'd2,
        RD_FETCH = 2'd3
    } t_rd_sel;

    // Division steps
    localparam logic [2:0] DIV_T  = 3'd0;
    localparam logic [2:0] DIV_Q0 = 3'd1;
    localparam logic [2:0] DIV_Q1 = 3'd2;

    // Multiply steps
    localparam logic [2:0] MUL_D0 = 3'd0;
    localparam logic [2:0] MUL_D1 = 3'd1;
    localparam logic [2:0] MUL_T2 = 3'd2;
    localparam logic [2:0] MUL_T3 = 3'd3;
    localparam logic [2:0] MUL_W0 = 3'd4;
    localparam logic [2:0] MUL_W1 = 3'd5;
    localparam logic [2:0] MUL_W2 = 3'd6;
    localparam logic [2:0] MUL_W3 = 3'd7;

    localparam logic [2:0] FETCH_LAST = 3'd4;

    typedef struct packed {
        logic        wr;
        logic        load;
        logic        cap_lo;
        logic        cap_range;
        logic        set_idx;
        logic        srch_upd;
        logic        fetch;
        logic        div_start;
        logic        div_cap;
        logic        mul_issue;
        logic        mul_use;
        logic        finish;
        t_rd_sel     rd_sel;
        logic [2:0]  step;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic size_zero;
        logic div_busy;
        logic out_full;
    } t_sts;

endpackage

// File: src/cri_div.sv
// Sequential restoring divider for a ratio saturated to [0, ONE].
module cri_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [32:0]    i_num,
    input  logic signed [32:0]    i_den,
    output logic                  o_busy,
    output logic [FRAC_BITS:0]    o_quo
);
    localparam int CW = $clog2(FRAC_BITS + 1);
    localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic [33:0]        num_abs, den_abs;
    logic               zero_res, sat_res;
    logic [34:0]        rem2;
    logic               ge;
    logic [33:0]        r_rem, r_den;
    logic [FRAC_BITS:0] r_quo;
    logic [CW-1:0]      r_cnt;

    always_comb begin
        num_abs  = i_num[32] ? 34'(-34'(i_num)) : 34'(i_num);
        den_abs  = i_den[32] ? 34'(-34'(i_den)) : 34'(i_den);
        zero_res = (i_den == 0) || (i_num == 0) || (i_num[32] != i_den[32]);
        sat_res  = !zero_res && (num_abs >= den_abs);
        rem2     = {r_rem, 1'b0};
        ge       = rem2 >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= (zero_res || sat_res) ? '0 : CW'(FRAC_BITS);
        end else if (r_cnt != 0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= num_abs;
            r_den <= den_abs;
            r_quo <= sat_res ? ONE_Q : '0;
        end else if (r_cnt != 0) begin
            r_rem <= ge ? 34'(rem2 - {1'b0, r_den}) : 34'(rem2);
            r_quo <= {r_quo[FRAC_BITS-1:0], ge};
        end
    end

    assign o_busy = r_cnt != 0;
    assign o_quo  = r_quo;

endmodule

// File: src/cri_dp.sv
// Datapath: node tables, search registers, divider, shared multiplier, output.
module cri_dp #(
    parameter int MAX_NODES = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cri_pkg::t_cmd        i_cmd_bus,
    output cri_pkg::t_sts        o_sts,
    input  logic                 i_cfg_we,
    input  logic [6:0]           i_cfg_data,
    input  logic [5:0]           i_entry_index,
    input  logic signed [31:0]   i_node_position,
    input  logic signed [31:0]   i_node_value,
    input  logic signed [31:0]   i_query_x,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic signed [31:0]   o_interp_value,
    output logic                 o_in_range
);
    import cri_pkg::*;

    localparam int AW   = $clog2(MAX_NODES);
    localparam int NW   = $clog2(MAX_NODES + 1);
    localparam int F    = FRAC_BITS;
    localparam int WW   = F + 3;
    localparam int PW   = 34 + WW;
    localparam int ACCW = PW + 2;
    localparam logic signed [WW-1:0]   ONE_W  = WW'(1) <<< F;
    localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(64'sd2147483647);
    localparam logic signed [ACCW-1:0] SAT_LO = ACCW'(-64'sd2147483648);

    logic signed [31:0] r_node_mem [MAX_NODES];
    logic signed [31:0] r_val_mem  [MAX_NODES];
    logic signed [31:0] r_node_rd, r_val_rd;

    logic [6:0]         r_cfg;
    logic [NW-1:0]      n_cfg, r_n, r_first, r_size, r_idx, half, mid, first_m1, n_m2;
    logic signed [31:0] r_x;
    logic               r_lo_ok, r_inr;
    logic [AW-1:0]      rd_addr;
    logic [NW:0]        fsum;

    logic signed [31:0] r_xs [4];
    logic signed [31:0] r_fs [4];
    logic [F:0]         r_t, r_q0, r_q1, r_t2, r_t3;
    logic signed [33:0] r_d0, r_d1;
    logic signed [PW-1:0]   r_prod, psh;
    logic signed [ACCW-1:0] r_acc, accsh, sat;

    logic signed [32:0] xme, x0e, x1e, x2e, width, num, den;
    logic signed [33:0] fme, f0e, f1e, f2e, mul_a;
    logic signed [WW-1:0] te, t2e, t3e, w0, w1, w2, w3, mul_b;
    logic               div_busy;
    logic [F:0]         div_quo;

    logic              r_out_valid, r_out_inr;
    logic signed [31:0] r_out_val;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 7'd2;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_cfg < 7'd2) begin
            n_cfg = NW'(2);
        end else if (32'(r_cfg) > MAX_NODES) begin
            n_cfg = NW'(MAX_NODES);
        end else begin
            n_cfg = NW'(r_cfg);
        end
    end

    // Table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.wr && (32'(i_entry_index) < MAX_NODES)) begin
            r_node_mem[AW'(i_entry_index)] <= i_node_position;
            r_val_mem[AW'(i_entry_index)]  <= i_node_value;
        end
        r_node_rd <= r_node_mem[rd_addr];
        r_val_rd  <= r_val_mem[rd_addr];
    end

    always_comb begin
        half     = r_size >> 1;
        mid      = r_first + half;
        first_m1 = r_first - 1'b1;
        n_m2     = r_n - NW'(2);
        fsum     = {1'b0, r_idx} + (NW + 1)'(i_cmd_bus.step);
        unique case (i_cmd_bus.rd_sel)
            RD_ZERO:  rd_addr = '0;
            RD_LAST:  rd_addr = AW'(r_n - 1'b1);
            RD_MID:   rd_addr = AW'(mid);
            RD_FETCH: rd_addr = (fsum == 0) ? '0 : AW'(fsum - 1'b1);
            default:  rd_addr = '0;
        endcase
    end

    // Range check and binary search
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load) begin
            r_x <= i_query_x;
            r_n <= n_cfg;
        end
        if (i_cmd_bus.cap_lo) begin
            r_lo_ok <= r_x >= r_node_rd;
        end
        if (i_cmd_bus.cap_range) begin
            r_inr   <= o_sts.in_range;
            r_first <= NW'(1);
            r_size  <= n_m2;
        end
        if (i_cmd_bus.srch_upd) begin
            if (r_node_rd <= r_x) begin
                r_first <= mid + 1'b1;
                r_size  <= r_size - half - 1'b1;
            end else begin
                r_size  <= half;
            end
        end
        if (i_cmd_bus.set_idx) begin
            r_idx <= (first_m1 > n_m2) ? n_m2 : first_m1;
        end
        if (i_cmd_bus.fetch && (i_cmd_bus.step != 0)) begin
            r_xs[2'(i_cmd_bus.step - 3'd1)] <= r_node_rd;
            r_fs[2'(i_cmd_bus.step - 3'd1)] <= r_val_rd;
        end
    end

    // Slot 0..3 hold entries idx-1 .. idx+2
    always_comb begin
        xme   = 33'(r_xs[0]);
        x0e   = 33'(r_xs[1]);
        x1e   = 33'(r_xs[2]);
        x2e   = 33'(r_xs[3]);
        fme   = 34'(r_fs[0]);
        f0e   = 34'(r_fs[1]);
        f1e   = 34'(r_fs[2]);
        f2e   = 34'(r_fs[3]);
        width = x1e - x0e;
        case (i_cmd_bus.step)
            DIV_T: begin
                num = 33'(r_x) - x0e;
                den = width;
            end
            DIV_Q0: begin
                num = width;
                den = x1e - xme;
            end
            default: begin
                num = width;
                den = x2e - x0e;
            end
        endcase
    end

    cri_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd_bus.div_start),
        .i_num   (num),
        .i_den   (den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.div_cap) begin
            case (i_cmd_bus.step)
                DIV_T:   r_t  <= div_quo;
                DIV_Q0:  r_q0 <= div_quo;
                default: r_q1 <= div_quo;
            endcase
        end
    end

    // Hermite basis weights
    always_comb begin
        te  = signed'(WW'(r_t));
        t2e = signed'(WW'(r_t2));
        t3e = signed'(WW'(r_t3));
        w0  = (t3e <<< 1) - (t2e <<< 1) - t2e + ONE_W;
        w1  = (t2e <<< 1) + t2e - (t3e <<< 1);
        w2  = t3e - (t2e <<< 1) + te;
        w3  = t3e - t2e;
        case (i_cmd_bus.step)
            MUL_D0: begin
                mul_a = f1e - fme;
                mul_b = signed'(WW'(r_q0));
            end
            MUL_D1: begin
                mul_a = f2e - f0e;
                mul_b = signed'(WW'(r_q1));
            end
            MUL_T2: begin
                mul_a = signed'(34'(r_t));
                mul_b = te;
            end
            MUL_T3: begin
                mul_a = signed'(34'(r_t2));
                mul_b = te;
            end
            MUL_W0: begin
                mul_a = f0e;
                mul_b = w0;
            end
            MUL_W1: begin
                mul_a = f1e;
                mul_b = w1;
            end
            MUL_W2: begin
                mul_a = r_d0;
                mul_b = w2;
            end
            default: begin
                mul_a = r_d1;
                mul_b = w3;
            end
        endcase
        psh = r_prod >>> F;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.mul_issue) begin
            r_prod <= PW'(mul_a * mul_b);
        end
        if (i_cmd_bus.mul_use) begin
            case (i_cmd_bus.step)
                MUL_D0: r_d0 <= (r_idx != 0) ? 34'(psh) : f1e - f0e;
                MUL_D1: r_d1 <= (({1'b0, r_idx} + (NW + 1)'(2)) < {1'b0, r_n}) ?
                                34'(psh) : f1e - f0e;
                MUL_T2: r_t2 <= (F + 1)'(psh);
                MUL_T3: r_t3 <= (F + 1)'(psh);
                MUL_W0: r_acc <= ACCW'(r_prod);
                default: r_acc <= r_acc + ACCW'(r_prod);
            endcase
        end
    end

    // Final scale and saturation
    always_comb begin
        accsh = r_acc >>> F;
        if (accsh > SAT_HI) begin
            sat = SAT_HI;
        end else if (accsh < SAT_LO) begin
            sat = SAT_LO;
        end else begin
            sat = accsh;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd_bus.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.finish) begin
            r_out_val <= r_inr ? 32'(sat) : '0;
            r_out_inr <= r_inr;
        end
    end

    always_comb begin
        o_sts.in_range  = r_lo_ok && (r_x <= r_node_rd);
        o_sts.size_zero = r_size == 0;
        o_sts.div_busy  = div_busy;
        o_sts.out_full  = r_out_valid;
    end

    assign o_out_valid    = r_out_valid;
    assign o_interp_value = r_out_val;
    assign o_in_range     = r_out_inr;

endmodule

// File: src/cri_ctrl.sv
// Controller state machine sequencing search, fetch, divide and multiply.
module cri_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_cmd,
    output logic           o_in_ready,
    output cri_pkg::t_cmd  o_cmd_bus,
    input  cri_pkg::t_sts  i_sts
);
    import cri_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_LO    = 11'b000_0000_0010,
        S_CHK   = 11'b000_0000_0100,
        S_SRCH  = 11'b000_0000_1000,
        S_SCMP  = 11'b000_0001_0000,
        S_FETCH = 11'b000_0010_0000,
        S_DIV   = 11'b000_0100_0000,
        S_DWAIT = 11'b000_1000_0000,
        S_MUL   = 11'b001_0000_0000,
        S_MACC  = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd_bus  = '0;
        o_cmd_bus.rd_sel = RD_ZERO;
        o_cmd_bus.step   = r_step;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_cmd) begin
                        o_cmd_bus.load = 1'b1;
                        n_state = S_LO;
                    end else begin
                        o_cmd_bus.wr = 1'b1;
                    end
                end
            end
            S_LO: begin
                o_cmd_bus.cap_lo = 1'b1;
                o_cmd_bus.rd_sel = RD_LAST;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd_bus.cap_range = 1'b1;
                n_state = i_sts.in_range ? S_SRCH : S_DONE;
            end
            S_SRCH: begin
                if (i_sts.size_zero) begin
                    o_cmd_bus.set_idx = 1'b1;
                    n_step  = '0;
                    n_state = S_FETCH;
                end else begin
                    o_cmd_bus.rd_sel = RD_MID;
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                o_cmd_bus.srch_upd = 1'b1;
                n_state = S_SRCH;
            end
            S_FETCH: begin
                o_cmd_bus.fetch  = 1'b1;
                o_cmd_bus.rd_sel = RD_FETCH;
                if (r_step == FETCH_LAST) begin
                    n_step  = DIV_T;
                    n_state = S_DIV;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DIV: begin
                o_cmd_bus.div_start = 1'b1;
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd_bus.div_cap = 1'b1;
                    if (r_step == DIV_Q1) begin
                        n_step  = MUL_D0;
                        n_state = S_MUL;
                    end else begin
                        n_step  = r_step + 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            S_MUL: begin
                o_cmd_bus.mul_issue = 1'b1;
                n_state = S_MACC;
            end
            S_MACC: begin
                o_cmd_bus.mul_use = 1'b1;
                if (r_step == MUL_W3) begin
                    n_state = S_DONE;
                end else begin
                    n_step  = r_step + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (!i_sts.out_full) begin
                    o_cmd_bus.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/catmull_rom_interpolator.sv
// Catmull-Rom spline interpolator top level: controller plus datapath.
//
// Holds up to MAX_NODES (position, value) pairs in signed Q16.16 (FRAC_BITS
// fraction bits), loaded by write transactions (i_cmd = 0), which produce no
// result. An evaluate transaction (i_cmd = 1) returns one result: 0 with
// o_in_range clear if i_query_x lies outside the first..last node in use,
// else the cubic Hermite value with finite-difference tangents, saturated to
// 32 bits. Nodes in use come from the config register (i_cfg_we /
// i_cfg_data, reset 2, clamped to [2, MAX_NODES]); write it only while idle.
// Node positions must be written and strictly increasing for a meaningful
// result. One evaluation at a time: an in-range query runs a binary search
// of at most ceil(log2(n-1)) steps, then the three bit-serial divisions
// (tangent ratios and t, each cut short when the ratio is zero or
// saturates), then eight passes through the one shared multiplier. An
// out-of-range query skips search, division and multiplication. The result
// waits while the previous result still sits unread in the output register.
// A finished result sits in the output register while the next transaction
// is accepted.
module catmull_rom_interpolator #(
    parameter int MAX_NODES = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [5:0]         i_entry_index,
    input  logic signed [31:0] i_node_position,
    input  logic signed [31:0] i_node_value,
    input  logic signed [31:0] i_query_x,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_interp_value,
    output logic               o_in_range
);
    import cri_pkg::*;

    t_cmd cmd_bus;
    t_sts sts;

    cri_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_ready (o_in_ready),
        .o_cmd_bus  (cmd_bus),
        .i_sts      (sts)
    );

    cri_dp #(
        .MAX_NODES (MAX_NODES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_bus       (cmd_bus),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_entry_index   (i_entry_index),
        .i_node_position (i_node_position),
        .i_node_value    (i_node_value),
        .i_query_x       (i_query_x),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_interp_value  (o_interp_value),
        .o_in_range      (o_in_range)
    );

    // Evaluate transaction makes the block busy
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_cmd) |=> !o_in_ready)
        else $error("ready stayed high after evaluate transaction");

    // Out-of-range result carries zero
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_in_range) |-> (o_interp_value == 0))
        else $error("out-of-range result not zero");

    // Write transaction never raises a result
    a_wr_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_cmd && !o_out_valid) |=> !o_out_valid)
        else $error("result produced by write transaction");

endmodule
